>>> design/scpe_pkg.sv
// Shared types, constants and ring-pointer helpers for the second-chance eviction core.
// No dependencies; every other design file uses it by scoped names.
package scpe_pkg;

	localparam int FRAMES = 64;
	localparam int FIDX_W = $clog2(FRAMES);
	localparam int CNT_W  = $clog2(FRAMES + 1);

	typedef logic [FIDX_W-1:0] fidx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic [2:0] OP_ATTACH = 3'd0;
	localparam logic [2:0] OP_DETACH = 3'd1;
	localparam logic [2:0] OP_ACCESS = 3'd2;
	localparam logic [2:0] OP_WRITE  = 3'd3;
	localparam logic [2:0] OP_EVICT  = 3'd4;

	typedef struct packed {
		logic [2:0] opcode;
		logic [5:0] frame_index;
		logic       is_leaf;
	} in_item_t;

	typedef struct packed {
		logic       victim_found;
		logic [5:0] victim_frame;
		logic       victim_dirty;
		logic [6:0] frames_held;
	} out_item_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_ATTACH,
		K_DETACH,
		K_MARK,
		K_EVICT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		fidx_t     frame;
		logic      leaf;
		logic      dirty;
	} cmd_t;

	// a + b modulo FRAMES, both operands below FRAMES
	function automatic fidx_t ring_add(fidx_t a, cnt_t b);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
		if (s >= (CNT_W + 1)'(FRAMES)) s = s - (CNT_W + 1)'(FRAMES);
		return FIDX_W'(s);
	endfunction

	function automatic fidx_t ring_dec(fidx_t a);
		return (a == '0) ? FIDX_W'(FRAMES - 1) : a - FIDX_W'(1);
	endfunction

endpackage

>>> design/scpe_front.sv
// Front end: accepts input beats, classifies them into commands, and queues them.
// Depends on scpe_pkg.
module scpe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scpe_pkg::in_item_t in_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output scpe_pkg::cmd_t    cmd
);

	scpe_pkg::cmd_t q_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	scpe_pkg::cmd_t cls;
	logic           idx_ok;
	logic           push;
	logic           pop;

	// classify
	always_comb begin
		idx_ok    = 32'(in_data.frame_index) < scpe_pkg::FRAMES;
		cls.frame = scpe_pkg::FIDX_W'(in_data.frame_index);
		cls.leaf  = in_data.is_leaf;
		cls.dirty = (in_data.opcode == scpe_pkg::OP_WRITE);
		case (in_data.opcode)
			scpe_pkg::OP_ATTACH: cls.kind = idx_ok ? scpe_pkg::K_ATTACH : scpe_pkg::K_NOP;
			scpe_pkg::OP_DETACH: cls.kind = idx_ok ? scpe_pkg::K_DETACH : scpe_pkg::K_NOP;
			scpe_pkg::OP_ACCESS,
			scpe_pkg::OP_WRITE:  cls.kind = idx_ok ? scpe_pkg::K_MARK : scpe_pkg::K_NOP;
			scpe_pkg::OP_EVICT:  cls.kind = scpe_pkg::K_EVICT;
			default:             cls.kind = scpe_pkg::K_NOP;
		endcase
	end

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) q_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> design/scpe_back.sv
// Back end: frame marks, arrival-order ring memory, evict/detach sequencer, result register.
// Depends on scpe_pkg.
module scpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mode,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  scpe_pkg::cmd_t      cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output scpe_pkg::out_item_t out_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_CHK  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                      state_q;
	scpe_pkg::cmd_t              cur_q;
	scpe_pkg::cnt_t              pos_q;
	scpe_pkg::fidx_t             carry_q;
	scpe_pkg::fidx_t             head_q;
	scpe_pkg::cnt_t              cnt_q;
	scpe_pkg::cnt_t              leafcnt_q;
	logic [scpe_pkg::FRAMES-1:0] member_q;
	logic [scpe_pkg::FRAMES-1:0] leaf_q;
	logic [scpe_pkg::FRAMES-1:0] acc_q;
	logic [scpe_pkg::FRAMES-1:0] dirty_q;
	scpe_pkg::fidx_t             mem [scpe_pkg::FRAMES];
	scpe_pkg::fidx_t             rdata_q;
	logic                        found_q;
	scpe_pkg::fidx_t             vframe_q;
	logic                        vdirty_q;
	scpe_pkg::out_item_t         out_q;
	logic                        out_valid_q;

	logic            we;
	scpe_pkg::fidx_t waddr;
	scpe_pkg::fidx_t wdata;
	scpe_pkg::fidx_t raddr;
	logic            take;
	logic            out_free;
	logic            victim_hit;
	logic            needs_scan;

	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign victim_hit = leaf_q[rdata_q] && !(mode && acc_q[rdata_q]);
	assign needs_scan = ((cmd.kind == scpe_pkg::K_DETACH) && member_q[cmd.frame])
		|| ((cmd.kind == scpe_pkg::K_EVICT) && (leafcnt_q != '0));

	always_comb begin
		raddr = (cur_q.kind == scpe_pkg::K_DETACH) ? scpe_pkg::ring_add(head_q, pos_q)
			: scpe_pkg::ring_add(head_q, cnt_q - scpe_pkg::CNT_W'(1));
		we    = 1'b0;
		waddr = scpe_pkg::ring_dec(head_q);
		wdata = cmd.frame;
		if (state_q == ST_IDLE) begin
			we = take && (cmd.kind == scpe_pkg::K_ATTACH) && !member_q[cmd.frame]
				&& (cnt_q < scpe_pkg::CNT_W'(scpe_pkg::FRAMES));
		end else if (state_q == ST_CHK) begin
			if (cur_q.kind == scpe_pkg::K_DETACH) begin
				we    = (pos_q != '0);
				waddr = scpe_pkg::ring_add(head_q, pos_q);
				wdata = carry_q;
			end else begin
				// rotate the oldest frame to the front
				we    = !victim_hit;
				wdata = rdata_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (state_q == ST_RD) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '{kind: scpe_pkg::K_NOP, default: '0};
			pos_q       <= '0;
			carry_q     <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			leafcnt_q   <= '0;
			member_q    <= '0;
			leaf_q      <= '0;
			acc_q       <= '0;
			dirty_q     <= '0;
			found_q     <= 1'b0;
			vframe_q    <= '0;
			vdirty_q    <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						cur_q    <= cmd;
						found_q  <= 1'b0;
						vframe_q <= '0;
						vdirty_q <= 1'b0;
						pos_q    <= '0;
						state_q  <= needs_scan ? ST_RD : ST_DONE;
						case (cmd.kind)
							scpe_pkg::K_ATTACH: begin
								if (we) begin
									member_q[cmd.frame] <= 1'b1;
									leaf_q[cmd.frame]   <= cmd.leaf;
									head_q    <= scpe_pkg::ring_dec(head_q);
									cnt_q     <= cnt_q + scpe_pkg::CNT_W'(1);
									leafcnt_q <= leafcnt_q + scpe_pkg::CNT_W'(cmd.leaf);
								end
							end
							scpe_pkg::K_DETACH: begin
								if (member_q[cmd.frame]) begin
									member_q[cmd.frame] <= 1'b0;
									leafcnt_q <= leafcnt_q
										- scpe_pkg::CNT_W'(leaf_q[cmd.frame]);
								end
							end
							scpe_pkg::K_MARK: begin
								acc_q[cmd.frame] <= 1'b1;
								if (cmd.dirty) dirty_q[cmd.frame] <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					if (cur_q.kind == scpe_pkg::K_DETACH) begin
						if (rdata_q == cur_q.frame) begin
							// earlier frames have slid back one slot; drop the old front
							head_q  <= scpe_pkg::ring_add(head_q, scpe_pkg::CNT_W'(1));
							cnt_q   <= cnt_q - scpe_pkg::CNT_W'(1);
							state_q <= ST_DONE;
						end else begin
							carry_q <= rdata_q;
							pos_q   <= pos_q + scpe_pkg::CNT_W'(1);
							state_q <= ST_RD;
						end
					end else begin
						if (victim_hit) begin
							found_q  <= 1'b1;
							vframe_q <= rdata_q;
							vdirty_q <= dirty_q[rdata_q];
							state_q  <= ST_DONE;
						end else begin
							if (leaf_q[rdata_q]) acc_q[rdata_q] <= 1'b0;
							head_q  <= scpe_pkg::ring_dec(head_q);
							state_q <= ST_RD;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.victim_found <= found_q;
						out_q.victim_frame <= 6'(vframe_q);
						out_q.victim_dirty <= vdirty_q;
						out_q.frames_held  <= 7'(cnt_q);
						out_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= scpe_pkg::CNT_W'(scpe_pkg::FRAMES))
		else $error("held count above capacity");

	a_leaf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		leafcnt_q <= cnt_q)
		else $error("leaf count above held count");

	a_evict_has_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && cur_q.kind == scpe_pkg::K_EVICT) |-> leafcnt_q != '0)
		else $error("evict scan without any held leaf");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> cnt_q != '0)
		else $error("scan on empty list");

endmodule

>>> design/second_chance_page_eviction_core.sv
// Top level of the second-chance page eviction core: config register, front, back.
// Depends on scpe_pkg, scpe_front, scpe_back.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, in_data      | item in
//  result  | out_valid, out_ready, out_data   | item out
//  config  | cfg_valid, cfg_ready, cfg_data   | policy_mode write
//
// Attach, detach of an absent frame, access, write and no-ops need no list scan in the back end.
// Detach reads and checks each list position in turn, from the front up to the frame.
// Evict reads the oldest frame once per rotation through one order-memory read port,
// up to 2*held+1 reads; evict with no leaf held does no scan.
// Reset clears all marks, count and policy_mode to 1 (second chance); the order memory needs none.
// A two-beat queue parts front and back, and the result register lets the back end work on
// an item while the previous result still waits; the new result is held until that one is taken.
module second_chance_page_eviction_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scpe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output scpe_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic           mode_q;
	logic           cmd_valid;
	logic           cmd_ready;
	scpe_pkg::cmd_t cmd;

	// the user writes config only while idle; the block does not enforce it and always takes it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	scpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	scpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
